// ===== design/mmor_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmor_pkg
// Shared types and codes of the memory map overlap resolver.
// ----------------------------------------------------------------------------
package mmor_pkg;

	// region types
	localparam logic [2:0] KIND_NONE     = 3'd0;
	localparam logic [2:0] KIND_FREE     = 3'd1;
	localparam logic [2:0] KIND_RESERVED = 3'd2;
	localparam logic [2:0] KIND_BAD      = 3'd5;
	localparam int         KIND_NUM      = 5;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_OVF   = 2'd2;

	// output register sources
	localparam logic [1:0] SRC_ENTRY = 2'd0;
	localparam logic [1:0] SRC_REG   = 2'd1;
	localparam logic [1:0] SRC_EMPTY = 2'd2;
	localparam logic [1:0] SRC_OVF   = 2'd3;

	typedef struct packed {
		logic [63:0] start;
		logic [63:0] size;
		logic [2:0]  kind;
		logic [31:0] attr;
	} region_t;

	typedef struct packed {
		logic       load_wr;
		logic       clear;
		logic       scan_rd;
		logic       scan_eval;
		logic       upd;
		logic       eval;
		logic       rd_entry0;
		logic       out_rd_reg;
		logic       out_load;
		logic [1:0] out_src;
		logic       out_adv;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic first_entry;
		logic ev_last;
		logic found;
		logic ovf_now;
		logic nreg_zero;
		logic out_last;
	} sts_t;

endpackage
`default_nettype wire

// ===== design/memory_map_overlap_resolver.sv =====
`default_nettype none
// Flow: non-final entries are accepted back to back. After the final entry of N stored entries,
// resolution runs one scan pass per event of the non-empty entries and a last pass that finds none;
// each scan pass reads and checks every event of the entry store to find the next event in order.
// Each result is then read, loaded and held until out_ready is seen; one map is worked at a time.
// Reset clears the controller, entry count and type counters; the stores need no clearing pass.
// ----------------------------------------------------------------------------
// memory_map_overlap_resolver
// Collects memory map entries and emits the sanitized non-overlapping regions.
// ----------------------------------------------------------------------------
module memory_map_overlap_resolver #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [63:0] region_start,
	input  wire  [63:0] region_size,
	input  wire  [31:0] raw_kind,
	input  wire  [31:0] attr_word,
	input  wire         final_entry,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [63:0] out_start,
	output logic [63:0] out_size,
	output logic [2:0]  out_kind,
	output logic [31:0] out_attr,
	output logic [1:0]  status,
	output logic        last_result
);
	mmor_pkg::cmd_t cmd;
	mmor_pkg::sts_t sts;

	// sequencer
	mmor_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.final_entry (final_entry),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	// stores and sweep logic
	mmor_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.region_start (region_start),
		.region_size  (region_size),
		.raw_kind     (raw_kind),
		.attr_word    (attr_word),
		.out_start    (out_start),
		.out_size     (out_size),
		.out_kind     (out_kind),
		.out_attr     (out_attr),
		.status       (status),
		.last_result  (last_result)
	);

`ifndef SYNTHESIS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while a result is pending");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != mmor_pkg::ST_OK |->
		last_result && out_kind == mmor_pkg::KIND_NONE)
		else $error("error result not alone");
	a_ok_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mmor_pkg::ST_OK && !in_ready |->
		out_kind != mmor_pkg::KIND_NONE || last_result)
		else $error("region without type");
`endif

endmodule
`default_nettype wire

// ===== design/mmor_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmor_datapath
// Entry and region stores, event scan, type sweep and output registers.
// ----------------------------------------------------------------------------
module mmor_datapath #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire mmor_pkg::cmd_t cmd,
	output mmor_pkg::sts_t      sts,
	input  wire  [63:0]         region_start,
	input  wire  [63:0]         region_size,
	input  wire  [31:0]         raw_kind,
	input  wire  [31:0]         attr_word,
	output logic [63:0]         out_start,
	output logic [63:0]         out_size,
	output logic [2:0]          out_kind,
	output logic [31:0]         out_attr,
	output logic [1:0]          status,
	output logic                last_result
);
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = IW + 1;
	localparam int KW = 64 + 1 + IW;
	localparam int KIND_NUM_L = mmor_pkg::KIND_NUM;

	// entry stores
	logic [63:0] start_mem [MAX_ENTRIES];
	logic [63:0] size_mem  [MAX_ENTRIES];
	logic [63:0] end_mem   [MAX_ENTRIES];
	logic        vld_mem   [MAX_ENTRIES];
	logic [2:0]  kind_mem  [MAX_ENTRIES];
	logic [31:0] attr_mem  [MAX_ENTRIES];
	mmor_pkg::region_t reg_mem [MAX_ENTRIES];

	logic [CW-1:0] count_q;
	logic [EW-1:0] ev_q;
	logic          found_q, have_prev_q;
	logic [KW-1:0] best_key_q, prev_key_q;
	logic [2:0]    best_kind_q;
	logic [31:0]   best_attr_q;
	logic [CW-1:0] cnt_q [KIND_NUM_L];
	logic [CW-1:0] nreg_q;
	logic [IW-1:0] out_idx_q;
	logic [2:0]    held_kind_q, open_type_q;
	logic [63:0]   open_base_q;
	logic [31:0]   open_attr_q;

	logic [63:0] rd_start_q, rd_size_q, rd_end_q;
	logic        rd_vld_q;
	logic [2:0]  rd_kind_q;
	logic [31:0] rd_attr_q;
	mmor_pkg::region_t rg_q;

	// kind mapping and entry write
	logic [2:0]  in_kind;
	logic [63:0] in_end;
	assign in_kind = (raw_kind >= 32'd1 && raw_kind <= 32'(mmor_pkg::KIND_BAD)) ?
		raw_kind[2:0] : mmor_pkg::KIND_RESERVED;
	assign in_end = region_start + region_size;

	always_ff @(posedge clk) begin
		if (cmd.load_wr && count_q < CW'(MAX_ENTRIES)) begin
			start_mem[count_q[IW-1:0]] <= region_start;
			size_mem[count_q[IW-1:0]]  <= region_size;
			end_mem[count_q[IW-1:0]]   <= in_end;
			vld_mem[count_q[IW-1:0]]   <= in_end > region_start;
			kind_mem[count_q[IW-1:0]]  <= in_kind;
			attr_mem[count_q[IW-1:0]]  <= attr_word;
		end
	end

	// entry store read port
	logic [IW-1:0] rd_idx;
	assign rd_idx = cmd.scan_rd ? ev_q[EW-1:1] : '0;

	always_ff @(posedge clk) begin
		if (cmd.scan_rd || cmd.rd_entry0) begin
			rd_start_q <= start_mem[rd_idx];
			rd_size_q  <= size_mem[rd_idx];
			rd_end_q   <= end_mem[rd_idx];
			rd_vld_q   <= vld_mem[rd_idx];
			rd_kind_q  <= kind_mem[rd_idx];
			rd_attr_q  <= attr_mem[rd_idx];
		end
	end

	// candidate event key: address, start after end, entry order
	logic [KW-1:0] cand_key;
	logic          cand_take;
	assign cand_key  = {(ev_q[0] ? rd_end_q : rd_start_q), ~ev_q[0], ev_q[EW-1:1]};
	assign cand_take = rd_vld_q && (!have_prev_q || cand_key > prev_key_q) &&
		(!found_q || cand_key < best_key_q);

	// highest type among active entries
	logic [2:0] cur_kind;
	always_comb begin
		cur_kind = mmor_pkg::KIND_NONE;
		for (int k = 0; k < KIND_NUM_L; k++) begin
			if (cnt_q[k] != '0) cur_kind = 3'(k + 1);
		end
	end

	logic [63:0] best_addr;
	logic        best_start;
	logic        emit_now;
	assign best_addr  = best_key_q[KW-1:KW-64];
	assign best_start = best_key_q[IW];
	assign emit_now   = cur_kind != held_kind_q && held_kind_q != mmor_pkg::KIND_NONE &&
		best_addr != open_base_q;

	// region store write
	always_ff @(posedge clk) begin
		if (cmd.eval && emit_now) begin
			reg_mem[nreg_q[IW-1:0]] <= '{start: open_base_q, size: best_addr - open_base_q,
				kind: open_type_q, attr: open_attr_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_rd_reg) rg_q <= reg_mem[out_idx_q];
	end

	// scan and sweep control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ev_q        <= '0;
			found_q     <= 1'b0;
			have_prev_q <= 1'b0;
			nreg_q      <= '0;
			out_idx_q   <= '0;
			held_kind_q <= mmor_pkg::KIND_NONE;
			for (int k = 0; k < KIND_NUM_L; k++) cnt_q[k] <= '0;
		end else begin
			if (cmd.load_wr && count_q < CW'(MAX_ENTRIES)) count_q <= count_q + 1'b1;
			if (cmd.finish) count_q <= '0;
			if (cmd.clear) begin
				ev_q        <= '0;
				found_q     <= 1'b0;
				have_prev_q <= 1'b0;
				nreg_q      <= '0;
				out_idx_q   <= '0;
				held_kind_q <= mmor_pkg::KIND_NONE;
				for (int k = 0; k < KIND_NUM_L; k++) cnt_q[k] <= '0;
			end
			if (cmd.scan_eval) begin
				ev_q <= ev_q + 1'b1;
				if (cand_take) found_q <= 1'b1;
			end
			if (cmd.upd) begin
				have_prev_q <= 1'b1;
				if (best_start) cnt_q[best_kind_q - 3'd1] <= cnt_q[best_kind_q - 3'd1] + 1'b1;
				else cnt_q[best_kind_q - 3'd1] <= cnt_q[best_kind_q - 3'd1] - 1'b1;
			end
			if (cmd.eval) begin
				ev_q        <= '0;
				found_q     <= 1'b0;
				held_kind_q <= cur_kind;
				if (emit_now) nreg_q <= nreg_q + 1'b1;
			end
			if (cmd.out_adv) out_idx_q <= out_idx_q + 1'b1;
		end
	end

	// best candidate and open region payload
	always_ff @(posedge clk) begin
		if (cmd.scan_eval && cand_take) begin
			best_key_q  <= cand_key;
			best_kind_q <= rd_kind_q;
			best_attr_q <= rd_attr_q;
		end
		if (cmd.upd) prev_key_q <= best_key_q;
		if (cmd.eval && cur_kind != held_kind_q && cur_kind != mmor_pkg::KIND_NONE) begin
			open_base_q <= best_addr;
			open_type_q <= cur_kind;
			open_attr_q <= best_attr_q;
		end
	end

	// output registers
	logic out_last_now;
	assign out_last_now = CW'(out_idx_q) + 1'b1 == nreg_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_src)
				mmor_pkg::SRC_ENTRY: begin
					out_start   <= rd_start_q;
					out_size    <= rd_size_q;
					out_kind    <= rd_kind_q;
					out_attr    <= rd_attr_q;
					status      <= mmor_pkg::ST_OK;
					last_result <= 1'b1;
				end
				mmor_pkg::SRC_REG: begin
					out_start   <= rg_q.start;
					out_size    <= rg_q.size;
					out_kind    <= rg_q.kind;
					out_attr    <= rg_q.attr;
					status      <= mmor_pkg::ST_OK;
					last_result <= out_last_now;
				end
				mmor_pkg::SRC_EMPTY: begin
					out_start   <= '0;
					out_size    <= '0;
					out_kind    <= mmor_pkg::KIND_NONE;
					out_attr    <= '0;
					status      <= mmor_pkg::ST_EMPTY;
					last_result <= 1'b1;
				end
				default: begin
					out_start   <= '0;
					out_size    <= '0;
					out_kind    <= mmor_pkg::KIND_NONE;
					out_attr    <= '0;
					status      <= mmor_pkg::ST_OVF;
					last_result <= 1'b1;
				end
			endcase
		end
	end

	// status to controller
	logic [CW:0] ev_end;
	assign ev_end = {count_q, 1'b0} - 1'b1;

	assign sts.first_entry = count_q == '0;
	assign sts.ev_last     = (CW + 1)'(ev_q) == ev_end;
	assign sts.found       = found_q;
	assign sts.ovf_now     = emit_now && nreg_q + 1'b1 >= CW'(MAX_ENTRIES);
	assign sts.nreg_zero   = nreg_q == '0;
	assign sts.out_last    = last_result;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond store depth");
	a_open_kind: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval && emit_now |-> open_type_q != mmor_pkg::KIND_NONE)
		else $error("region closed with no type");
	a_upd_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> found_q && best_kind_q != mmor_pkg::KIND_NONE)
		else $error("sweep step without an event");
`endif

endmodule
`default_nettype wire

// ===== design/mmor_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmor_ctrl
// Sequencer for load, event scan passes, sweep steps and result output.
// ----------------------------------------------------------------------------
module mmor_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire                 final_entry,
	output logic                out_valid,
	input  wire                 out_ready,
	output mmor_pkg::cmd_t      cmd,
	input  wire mmor_pkg::sts_t sts
);
	localparam logic [3:0] S_LOAD   = 4'd0;
	localparam logic [3:0] S_PT_RD  = 4'd1;
	localparam logic [3:0] S_PT_LD  = 4'd2;
	localparam logic [3:0] S_INIT   = 4'd3;
	localparam logic [3:0] S_SCAN_A = 4'd4;
	localparam logic [3:0] S_SCAN_B = 4'd5;
	localparam logic [3:0] S_PICK   = 4'd6;
	localparam logic [3:0] S_EVAL   = 4'd7;
	localparam logic [3:0] S_OVF    = 4'd8;
	localparam logic [3:0] S_EMPTY  = 4'd9;
	localparam logic [3:0] S_ORD    = 4'd10;
	localparam logic [3:0] S_OLD    = 4'd11;
	localparam logic [3:0] S_WAIT   = 4'd12;

	logic [3:0] state_q, state_d;

	assign in_ready  = state_q == S_LOAD;
	assign out_valid = state_q == S_WAIT;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.load_wr = 1'b1;
					if (final_entry) state_d = sts.first_entry ? S_PT_RD : S_INIT;
				end
			end
			S_PT_RD: begin
				cmd.rd_entry0 = 1'b1;
				state_d       = S_PT_LD;
			end
			S_PT_LD: begin
				cmd.out_load = 1'b1;
				cmd.out_src  = mmor_pkg::SRC_ENTRY;
				state_d      = S_WAIT;
			end
			S_INIT: begin
				cmd.clear = 1'b1;
				state_d   = S_SCAN_A;
			end
			S_SCAN_A: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_SCAN_B;
			end
			S_SCAN_B: begin
				cmd.scan_eval = 1'b1;
				state_d       = sts.ev_last ? S_PICK : S_SCAN_A;
			end
			S_PICK: begin
				if (sts.found) begin
					cmd.upd = 1'b1;
					state_d = S_EVAL;
				end else begin
					state_d = sts.nreg_zero ? S_EMPTY : S_ORD;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.ovf_now ? S_OVF : S_SCAN_A;
			end
			S_OVF: begin
				cmd.out_load = 1'b1;
				cmd.out_src  = mmor_pkg::SRC_OVF;
				state_d      = S_WAIT;
			end
			S_EMPTY: begin
				cmd.out_load = 1'b1;
				cmd.out_src  = mmor_pkg::SRC_EMPTY;
				state_d      = S_WAIT;
			end
			S_ORD: begin
				cmd.out_rd_reg = 1'b1;
				state_d        = S_OLD;
			end
			S_OLD: begin
				cmd.out_load = 1'b1;
				cmd.out_src  = mmor_pkg::SRC_REG;
				state_d      = S_WAIT;
			end
			S_WAIT: begin
				if (out_ready) begin
					if (sts.out_last) begin
						cmd.finish = 1'b1;
						state_d    = S_LOAD;
					end else begin
						cmd.out_adv = 1'b1;
						state_d     = S_ORD;
					end
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_LOAD;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

// ===== test/memory_map_overlap_resolver_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// memory_map_overlap_resolver_tb
// Feeds memory maps entry by entry, predicts the sanitized region list of each
// map with a behavioral sweep, and checks every result transaction in order.
// ----------------------------------------------------------------------------
module memory_map_overlap_resolver_tb;

	localparam int MAX_ENTRIES = 32;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [63:0] start;
		logic [63:0] size;
		logic [2:0]  kind;
		logic [31:0] attr;
		logic [1:0]  status;
		logic        last;
	} region_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] region_start = '0;
	logic [63:0] region_size = '0;
	logic [31:0] raw_kind = '0;
	logic [31:0] attr_word = '0;
	logic        final_entry = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] out_start;
	logic [63:0] out_size;
	logic [2:0]  out_kind;
	logic [31:0] out_attr;
	logic [1:0]  status;
	logic        last_result;

	memory_map_overlap_resolver #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.region_start(region_start), .region_size(region_size),
		.raw_kind(raw_kind), .attr_word(attr_word), .final_entry(final_entry),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_start(out_start), .out_size(out_size), .out_kind(out_kind),
		.out_attr(out_attr), .status(status), .last_result(last_result)
	);

	always #5 clk = ~clk;

	// predictor state: entries of the map being collected
	logic [63:0] map_start [MAX_ENTRIES];
	logic [63:0] map_size  [MAX_ENTRIES];
	logic [2:0]  map_kind  [MAX_ENTRIES];
	logic [31:0] map_attr  [MAX_ENTRIES];
	int          map_count = 0;
	int          sweep_order [2*MAX_ENTRIES];
	bit          covering [MAX_ENTRIES];
	region_result_t swept [MAX_ENTRIES];

	region_result_t expected_regions [$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent = 0;

	function automatic logic [63:0] event_addr(int ev);
		int e;
		e = ev >> 1;
		return (ev & 1) ? map_start[e] + map_size[e] : map_start[e];
	endfunction

	// end events first at one address, then arrival order
	function automatic bit event_precedes(int a, int b);
		logic [63:0] aa, ab;
		aa = event_addr(a);
		ab = event_addr(b);
		if (aa != ab) return aa < ab;
		if ((a & 1) != (b & 1)) return (a & 1) != 0;
		return (a >> 1) < (b >> 1);
	endfunction

	// sweep the stored map; returns region count or -1 on overflow
	function automatic int sweep_map();
		int nev, nreg, v, j, ev, e;
		logic [63:0] mark_addr, open_base, addr;
		logic [2:0] held_kind, open_type, cur;
		logic [31:0] open_attr;
		nev = 0;
		nreg = 0;
		mark_addr = '0;
		open_base = '0;
		held_kind = mmor_pkg::KIND_NONE;
		open_type = mmor_pkg::KIND_NONE;
		open_attr = '0;
		for (int i = 0; i < map_count; i++) begin
			covering[i] = 1'b0;
			if (map_start[i] + map_size[i] <= map_start[i]) continue;
			sweep_order[nev++] = 2*i;
			sweep_order[nev++] = 2*i + 1;
		end
		for (int i = 1; i < nev; i++) begin
			v = sweep_order[i];
			j = i;
			while (j > 0 && event_precedes(v, sweep_order[j-1])) begin
				sweep_order[j] = sweep_order[j-1];
				j--;
			end
			sweep_order[j] = v;
		end
		for (int i = 0; i < nev; i++) begin
			ev = sweep_order[i];
			e = ev >> 1;
			addr = event_addr(ev);
			covering[e] = (ev & 1) == 0;
			cur = mmor_pkg::KIND_NONE;
			for (int k = 0; k < map_count; k++)
				if (covering[k] && map_kind[k] > cur) cur = map_kind[k];
			if (cur == held_kind) continue;
			if (held_kind != mmor_pkg::KIND_NONE && addr != mark_addr) begin
				swept[nreg] = '{open_base, addr - mark_addr, open_type, open_attr,
					mmor_pkg::ST_OK, 1'b0};
				nreg++;
				if (nreg >= MAX_ENTRIES) return -1;
			end
			if (cur != mmor_pkg::KIND_NONE) begin
				open_base = addr;
				open_type = cur;
				open_attr = map_attr[e];
				mark_addr = addr;
			end
			held_kind = cur;
		end
		return nreg;
	endfunction

	// update the predictor with one accepted entry
	task automatic predict_entry(logic [63:0] s, logic [63:0] n, logic [31:0] k,
			logic [31:0] a, logic fin);
		logic [2:0] kind;
		int nreg;
		kind = (k < 32'd1 || k > 32'(mmor_pkg::KIND_BAD)) ? mmor_pkg::KIND_RESERVED : k[2:0];
		if (map_count < MAX_ENTRIES) begin
			map_start[map_count] = s;
			map_size[map_count] = n;
			map_kind[map_count] = kind;
			map_attr[map_count] = a;
			map_count++;
		end
		if (!fin) return;
		if (map_count == 1) begin
			expected_regions.push_back('{map_start[0], map_size[0], map_kind[0],
				map_attr[0], mmor_pkg::ST_OK, 1'b1});
		end else begin
			nreg = sweep_map();
			if (nreg < 0)
				expected_regions.push_back('{'0, '0, mmor_pkg::KIND_NONE, '0,
					mmor_pkg::ST_OVF, 1'b1});
			else if (nreg == 0)
				expected_regions.push_back('{'0, '0, mmor_pkg::KIND_NONE, '0,
					mmor_pkg::ST_EMPTY, 1'b1});
			else
				for (int i = 0; i < nreg; i++) begin
					swept[i].last = (i == nreg - 1);
					expected_regions.push_back(swept[i]);
				end
		end
		map_count = 0;
	endtask

	// drive one entry and hold it until accepted
	task automatic send_entry(logic [63:0] s, logic [63:0] n, logic [31:0] k,
			logic [31:0] a, logic fin);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		region_start <= s;
		region_size <= n;
		raw_kind <= k;
		attr_word <= a;
		final_entry <= fin;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_entry(s, n, k, a, fin);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_regions.size() != 0) @(posedge clk);
	endtask

	// receiver stall pattern
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// result checker
	always @(posedge clk) begin
		region_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_regions.size() == 0) begin
				$error("unexpected result transaction start=%h", out_start);
				errors++;
			end else begin
				exp_r = expected_regions.pop_front();
				if (out_start !== exp_r.start) begin
					$error("out_start exp %h got %h", exp_r.start, out_start); errors++;
				end
				if (out_size !== exp_r.size) begin
					$error("out_size exp %h got %h", exp_r.size, out_size); errors++;
				end
				if (out_kind !== exp_r.kind) begin
					$error("out_kind exp %0d got %0d", exp_r.kind, out_kind); errors++;
				end
				if (out_attr !== exp_r.attr) begin
					$error("out_attr exp %h got %h", exp_r.attr, out_attr); errors++;
				end
				if (status !== exp_r.status) begin
					$error("status exp %0d got %0d", exp_r.status, status); errors++;
				end
				if (last_result !== exp_r.last) begin
					$error("last_result exp %0d got %0d", exp_r.last, last_result);
					errors++;
				end
			end
		end
	end

	// watchdog
	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// single entry passes through with only its type mapped, even if it wraps
	task automatic test_single_entry();
		send_entry('1, '1, 32'd0, '1, 1'b1);
		send_entry('0, '0, 32'd5, '0, 1'b1);
		send_entry(64'h1000, 64'h2000, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1);
	endtask

	// only wrapping or zero-length entries leave nothing
	task automatic test_empty_map();
		send_entry(64'h5000, '0, 32'd1, 32'hA, 1'b0);
		send_entry('1, 64'h10, 32'd3, 32'hB, 1'b1);
		wait_drained();
	endtask

	// all types overlapping, unknown types become reserved
	task automatic test_kind_priority();
		send_entry(64'h0, 64'h1000, 32'd1, 32'h11, 1'b0);
		send_entry(64'h100, 64'h100, 32'd3, 32'h33, 1'b0);
		send_entry(64'h180, 64'h200, 32'd4, 32'h44, 1'b0);
		send_entry(64'h800, 64'h100, 32'd6, 32'h66, 1'b0);
		send_entry(64'h900, 64'h10, 32'd5, 32'h55, 1'b0);
		send_entry(64'hF00, 64'h300, 32'd2, 32'h22, 1'b1);
		wait_drained();
	endtask

	// touching entries and equal addresses
	task automatic test_equal_addresses();
		send_entry(64'h2000, 64'h1000, 32'd1, 32'h1, 1'b0);
		send_entry(64'h3000, 64'h1000, 32'd1, 32'h2, 1'b0);
		send_entry(64'h3000, 64'h800, 32'd1, 32'h3, 1'b0);
		send_entry(64'h2000, 64'h1000, 32'd2, 32'h4, 1'b0);
		send_entry(64'hFFFF_FFFF_FFFF_F000, 64'h1000, 32'd4, '1, 1'b1);
		wait_drained();
	endtask

	// full store drops further entries; final one still resolves
	task automatic test_full_store();
		for (int i = 0; i < MAX_ENTRIES + 2; i++)
			send_entry(64'h1_0000 + 64'(i) * 64'h10, 64'h8, 32'(1 + i % 5),
				32'(i), i == MAX_ENTRIES + 1);
		wait_drained();
	endtask

	// disjoint entries filling every region slot overflow
	task automatic test_overflow();
		for (int i = 0; i < MAX_ENTRIES; i++)
			send_entry(64'h4000_0000 + 64'(i) * 64'h1000, 64'h800, 32'd1,
				32'(i), i == MAX_ENTRIES - 1);
		wait_drained();
	endtask

	// random maps, mostly short and clustered so entries overlap
	task automatic test_random_maps(int count);
		int len;
		logic [63:0] base, s, n;
		logic [31:0] k;
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			len = ($urandom_range(99) < 2) ? $urandom_range(30, 36) :
				($urandom_range(99) < 10) ? $urandom_range(7, 16) : $urandom_range(1, 6);
			base = rand64() & ~64'hFFFF;
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(9))
					0: begin s = rand64(); n = rand64(); end
					1: begin s = '1 - 64'($urandom_range(0, 64)); n = 64'($urandom_range(0, 128)); end
					2: begin s = base + 64'($urandom_range(0, 15)) * 64'h100; n = '0; end
					default: begin
						s = base + 64'($urandom_range(0, 15)) * 64'h100;
						n = 64'($urandom_range(1, 16)) * 64'h100;
					end
				endcase
				k = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(1, 5));
				send_entry(s, n, k, $urandom, i == len - 1);
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_entry();
		test_empty_map();
		test_kind_priority();
		test_equal_addresses();
		test_full_store();
		test_overflow();
		send_idle_pct = 9;
		recv_idle_pct = 79;
		test_random_maps(125);
		wait_drained();
		send_idle_pct = 79;
		recv_idle_pct = 9;
		test_random_maps(125);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_maps(125);
		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_regions.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
